// File: rtl/lfs_pkg.sv
// Shared types and constants of the looped frame sequencer.
`timescale 1ns / 1ps

package lfs_pkg;

    localparam int FRAME_BITS_DEF = 16;
    localparam int SKIP_BITS_DEF  = 8;
    localparam int TICK_BITS      = 16;
    localparam int MODE_BITS      = 3;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SEEK = 2'd1,
        OP_ACK  = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NUM,
        ST_WIN,
        ST_SKIP,
        ST_DONE
    } state_t;

    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_FRAMES   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_FRAME  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STOP_FRAME   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SKIP         = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLAY_MODE    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD_TICKS = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_SYNC_ENABLED = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_IS_LEADER    = 3'd7;

    localparam logic [MODE_BITS-1:0] MODE_STOPPED  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_FORWARD  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_BACKWARD = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_PP_FWD   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_PP_BWD   = 3'd4;

endpackage

// File: rtl/looped_frame_sequencer.sv
// Top level of the looped frame sequencer with its shared remainder unit and sequencer.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid, in_stall   | opcode, frame
// output   | out       | out_valid, out_stall | changed, request_issued, requested_frame,
//          |           |                      | current_frame, unexpected_frame
// config   | in        | cfg_write            | cfg_index, cfg_data
//
// A seek, or a tick that advances, runs through ST_NUM, ST_WIN and ST_SKIP, where
// one restoring remainder unit that retires one bit per cycle is used three times in
// turn on a W-bit dividend, W being the larger of FRAME_BITS and SKIP_BITS plus two.
// Any other item goes from ST_IDLE straight to ST_DONE.
// Reset restores the FSM and architectural state. A waiting result does not hold up
// the next transfer on the input side until the following result is ready.

module looped_frame_sequencer #(
    parameter int FRAME_BITS = lfs_pkg::FRAME_BITS_DEF,
    parameter int SKIP_BITS  = lfs_pkg::SKIP_BITS_DEF,
    localparam int FS_MAX    = (FRAME_BITS > SKIP_BITS) ? FRAME_BITS : SKIP_BITS,
    localparam int CFG_W     = (FS_MAX > lfs_pkg::TICK_BITS) ? FS_MAX : lfs_pkg::TICK_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [lfs_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_W-1:0]                 cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       opcode,
    input  logic signed [FRAME_BITS:0]       frame,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             changed,
    output logic                             request_issued,
    output logic [FRAME_BITS-1:0]            requested_frame,
    output logic [FRAME_BITS-1:0]            current_frame,
    output logic                             unexpected_frame
);

    import lfs_pkg::*;

    localparam int W     = FS_MAX + 2;
    localparam int DSW   = (FRAME_BITS + 1 > SKIP_BITS) ? FRAME_BITS + 1 : SKIP_BITS;
    localparam int CNT_W = $clog2(W + 1);
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    // Configuration registers.
    logic [FRAME_BITS-1:0] num_frames_reg;
    logic [FRAME_BITS-1:0] start_frame_reg;
    logic [FRAME_BITS-1:0] stop_frame_reg;
    logic [SKIP_BITS-1:0]  skip_reg;
    logic [MODE_BITS-1:0]  play_mode_reg;
    logic [TICK_BITS-1:0]  period_ticks_reg;
    logic                  sync_enabled_reg;
    logic                  is_leader_reg;

    // Sequencer state.
    state_t st_reg, st_next;
    opcode_t op_reg, op_next;
    logic [FRAME_BITS:0]   frm_reg, frm_next;
    logic                  calc_reg, calc_next;
    logic [W-1:0]          dvd_reg, dvd_next;
    logic [DSW-1:0]        rem_reg, rem_next;
    logic [DSW-1:0]        dsr_reg, dsr_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [FRAME_BITS-1:0] base_reg, base_next;

    // Architectural state.
    logic [FRAME_BITS-1:0] committed_reg, committed_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [FRAME_BITS-1:0] pend_frame_reg, pend_frame_next;
    logic                  rep_valid_reg, rep_valid_next;
    logic [FRAME_BITS-1:0] rep_frame_reg, rep_frame_next;
    logic                  dir_reg, dir_next;
    logic [TICK_BITS-1:0]  tick_reg, tick_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic                  changed_reg, changed_next;
    logic                  req_issued_reg, req_issued_next;
    logic [FRAME_BITS-1:0] req_frame_reg, req_frame_next;
    logic                  unexp_reg, unexp_next;

    // Shared remainder unit and helpers.
    logic [DSW:0]          trial;
    logic [DSW:0]          trial_sub;
    logic [DSW-1:0]        rem_step;
    logic [SKIP_BITS-1:0]  skip_eff;
    logic [FRAME_BITS:0]   win_w;
    logic                  win_ok;
    logic [FRAME_BITS-1:0] r1;
    logic [FRAME_BITS-1:0] v1;
    logic [FRAME_BITS:0]   x_val;
    logic [FRAME_BITS:0]   x_mag;
    logic [FRAME_BITS:0]   r2;
    logic [FRAME_BITS:0]   adj;
    logic [FRAME_BITS-1:0] v2;
    logic signed [W-1:0]   sum_val;
    logic signed [W-1:0]   seek_val;
    logic signed [W-1:0]   start_val;
    logic [TICK_BITS-1:0]  tick_inc;
    logic                  playing;
    logic                  ping_pong;
    logic                  backward;
    logic                  advance;
    logic                  dir_acc;
    logic                  out_free;

    assign in_stall         = (st_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign changed          = changed_reg;
    assign request_issued   = req_issued_reg;
    assign requested_frame  = req_frame_reg;
    assign current_frame    = committed_reg;
    assign unexpected_frame = unexp_reg;

    assign skip_eff = (skip_reg == '0) ? SKIP_BITS'(1) : skip_reg;
    assign win_ok   = (stop_frame_reg >= start_frame_reg);
    assign win_w    = {1'b0, stop_frame_reg} - {1'b0, start_frame_reg} + (FRAME_BITS + 1)'(1);
    assign out_free = !out_valid_reg || !out_stall;

    assign trial     = {rem_reg, dvd_reg[W-1]};
    assign trial_sub = trial - {1'b0, dsr_reg};
    assign rem_step  = (trial >= {1'b0, dsr_reg}) ? trial_sub[DSW-1:0] : trial[DSW-1:0];

    assign r1    = rem_reg[FRAME_BITS-1:0];
    assign v1    = (num_frames_reg == '0) ? '0 :
                   (neg_reg && r1 != '0) ? num_frames_reg - r1 : r1;
    assign x_val = {1'b0, v1} - {1'b0, start_frame_reg};
    assign x_mag = x_val[FRAME_BITS] ? -x_val : x_val;
    assign r2    = rem_reg[FRAME_BITS:0];
    assign adj   = (neg_reg && r2 != '0) ? win_w - r2 : r2;
    assign v2    = win_ok ? start_frame_reg + adj[FRAME_BITS-1:0] : start_frame_reg;

    assign tick_inc  = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + TICK_BITS'(1);
    assign playing   = (play_mode_reg >= MODE_FORWARD) && (play_mode_reg <= MODE_PP_BWD);
    assign ping_pong = (play_mode_reg == MODE_PP_FWD) || (play_mode_reg == MODE_PP_BWD);
    assign backward  = (play_mode_reg == MODE_BACKWARD) || (play_mode_reg == MODE_PP_BWD);
    assign advance   = playing && (!sync_enabled_reg || is_leader_reg) &&
                       (period_ticks_reg == '0 || tick_inc >= period_ticks_reg);

    always_comb
    begin
        dir_acc = dir_reg;
        if (ping_pong)
        begin
            if (committed_reg >= stop_frame_reg)
            begin
                dir_acc = 1'b0;
            end
            if (committed_reg <= start_frame_reg)
            begin
                dir_acc = 1'b1;
            end
        end
        else
        begin
            dir_acc = 1'b1;
        end
    end

    assign sum_val  = (dir_acc ^ backward) ?
                      W'(committed_reg) + W'(skip_eff) :
                      W'(committed_reg) - W'(skip_eff);
    assign seek_val = {{(W - FRAME_BITS - 1){frame[FRAME_BITS]}}, frame};
    assign start_val = (opcode_t'(opcode) == OP_SEEK) ? seek_val : sum_val;

    always_comb
    begin
        st_next         = st_reg;
        op_next         = op_reg;
        frm_next        = frm_reg;
        calc_next       = calc_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        base_next       = base_reg;
        committed_next  = committed_reg;
        pend_valid_next = pend_valid_reg;
        pend_frame_next = pend_frame_reg;
        rep_valid_next  = rep_valid_reg;
        rep_frame_next  = rep_frame_reg;
        dir_next        = dir_reg;
        tick_next       = tick_reg;
        out_valid_next  = out_valid_reg && out_stall;
        changed_next    = changed_reg;
        req_issued_next = req_issued_reg;
        req_frame_next  = req_frame_reg;
        unexp_next      = unexp_reg;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = opcode_t'(opcode);
                    frm_next  = frame;
                    dvd_next  = start_val[W-1] ? W'(-start_val) : W'(start_val);
                    neg_next  = start_val[W-1];
                    dsr_next  = DSW'(num_frames_reg);
                    rem_next  = '0;
                    cnt_next  = CNT_W'(W);
                    calc_next = 1'b0;
                    if (opcode_t'(opcode) == OP_SEEK)
                    begin
                        calc_next = 1'b1;
                    end
                    else if (opcode_t'(opcode) == OP_TICK)
                    begin
                        tick_next = tick_inc;
                        if (advance)
                        begin
                            calc_next = 1'b1;
                            dir_next  = dir_acc;
                        end
                    end
                    if (opcode_t'(opcode) == OP_SEEK ||
                        (opcode_t'(opcode) == OP_TICK && advance))
                    begin
                        st_next = ST_NUM;
                    end
                    else
                    begin
                        st_next = ST_DONE;
                    end
                end
            end
            ST_NUM:
            begin
                if (cnt_reg != '0)
                begin
                    rem_next = rem_step;
                    dvd_next = {dvd_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    dvd_next = W'(x_mag);
                    neg_next = x_val[FRAME_BITS];
                    dsr_next = DSW'(win_w);
                    rem_next = '0;
                    cnt_next = CNT_W'(W);
                    st_next  = ST_WIN;
                end
            end
            ST_WIN:
            begin
                if (cnt_reg != '0)
                begin
                    rem_next = rem_step;
                    dvd_next = {dvd_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    base_next = v2;
                    dvd_next  = W'(v2);
                    neg_next  = 1'b0;
                    dsr_next  = DSW'(skip_eff);
                    rem_next  = '0;
                    cnt_next  = CNT_W'(W);
                    st_next   = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (cnt_reg != '0)
                begin
                    rem_next = rem_step;
                    dvd_next = {dvd_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    base_next = base_reg - rem_reg[FRAME_BITS-1:0];
                    st_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    changed_next    = 1'b0;
                    req_issued_next = 1'b0;
                    req_frame_next  = '0;
                    unexp_next      = 1'b0;
                    if (calc_reg)
                    begin
                        req_frame_next = base_reg;
                        if (committed_reg != base_reg && !pend_valid_reg)
                        begin
                            changed_next    = 1'b1;
                            req_issued_next = 1'b1;
                            pend_valid_next = 1'b1;
                            pend_frame_next = base_reg;
                        end
                        if (sync_enabled_reg && (!rep_valid_reg || rep_frame_reg != base_reg))
                        begin
                            rep_valid_next = 1'b1;
                            rep_frame_next = base_reg;
                            changed_next   = 1'b1;
                        end
                    end
                    else if (op_reg == OP_ACK)
                    begin
                        unexp_next      = pend_valid_reg && (frm_reg != {1'b0, pend_frame_reg});
                        pend_valid_next = 1'b0;
                        if (committed_reg != frm_reg[FRAME_BITS-1:0])
                        begin
                            committed_next = frm_reg[FRAME_BITS-1:0];
                            tick_next      = '0;
                        end
                    end
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_frames_reg   <= '0;
            start_frame_reg  <= '0;
            stop_frame_reg   <= '0;
            skip_reg         <= SKIP_BITS'(1);
            play_mode_reg    <= MODE_FORWARD;
            period_ticks_reg <= TICK_BITS'(1);
            sync_enabled_reg <= 1'b1;
            is_leader_reg    <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NUM_FRAMES:   num_frames_reg   <= cfg_data[FRAME_BITS-1:0];
                REG_START_FRAME:  start_frame_reg  <= cfg_data[FRAME_BITS-1:0];
                REG_STOP_FRAME:   stop_frame_reg   <= cfg_data[FRAME_BITS-1:0];
                REG_SKIP:         skip_reg         <= cfg_data[SKIP_BITS-1:0];
                REG_PLAY_MODE:    play_mode_reg    <= cfg_data[MODE_BITS-1:0];
                REG_PERIOD_TICKS: period_ticks_reg <= cfg_data[TICK_BITS-1:0];
                REG_SYNC_ENABLED: sync_enabled_reg <= cfg_data[0];
                REG_IS_LEADER:    is_leader_reg    <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            committed_reg  <= '0;
            pend_valid_reg <= 1'b0;
            pend_frame_reg <= '0;
            rep_valid_reg  <= 1'b0;
            rep_frame_reg  <= '0;
            dir_reg        <= 1'b1;
            tick_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            committed_reg  <= committed_next;
            pend_valid_reg <= pend_valid_next;
            pend_frame_reg <= pend_frame_next;
            rep_valid_reg  <= rep_valid_next;
            rep_frame_reg  <= rep_frame_next;
            dir_reg        <= dir_next;
            tick_reg       <= tick_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        frm_reg        <= frm_next;
        calc_reg       <= calc_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        dsr_reg        <= dsr_next;
        neg_reg        <= neg_next;
        cnt_reg        <= cnt_next;
        base_reg       <= base_next;
        changed_reg    <= changed_next;
        req_issued_reg <= req_issued_next;
        req_frame_reg  <= req_frame_next;
        unexp_reg      <= unexp_next;
    end

endmodule

// File: test/looped_frame_sequencer_tb.sv
// Self-checking testbench of the looped frame sequencer against a behavioural predictor.
`timescale 1ns / 1ps

module looped_frame_sequencer_tb;

    import lfs_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 70;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 3'd6;

    typedef struct packed {
        logic        changed;
        logic        request_issued;
        logic [15:0] requested_frame;
        logic [15:0] current_frame;
        logic        unexpected_frame;
    } seq_outcome_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  opcode;
    logic [16:0] frame;
    logic        out_valid;
    logic        out_stall;
    logic        changed;
    logic        request_issued;
    logic [15:0] requested_frame;
    logic [15:0] current_frame;
    logic        unexpected_frame;

    seq_outcome_t outcome_q[$];
    bit           failed;
    int           send_idle_pct;
    int           recv_stall_pct;
    longint       cycles;

    // Predictor copy of the registers.
    longint          n_frames;
    longint          win_start;
    longint          win_stop;
    longint          step_size;
    logic [2:0]      mode;
    longint          period;
    bit              shared_tl;
    bit              leader;

    // Predictor copy of the sequencer state.
    logic [15:0] committed;
    bit          req_pending;
    logic [15:0] req_frame;
    bit          rep_valid;
    logic [15:0] rep_frame;
    bit          going_fwd;
    logic [15:0] ticks;

    looped_frame_sequencer u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .frame            (frame),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .changed          (changed),
        .request_issued   (request_issued),
        .requested_frame  (requested_frame),
        .current_frame    (current_frame),
        .unexpected_frame (unexpected_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, outcome_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic logic [15:0] fold_frame(input longint f);
        longint v;
        longint w;
        longint s;
        v = 0;
        s = (step_size == 0) ? 1 : step_size;
        if (n_frames != 0)
        begin
            v = f % n_frames;
            if (v < 0)
                v += n_frames;
        end
        if (win_stop >= win_start)
        begin
            w = win_stop - win_start + 1;
            v = (v - win_start) % w;
            if (v < 0)
                v += w;
            v += win_start;
        end
        else
            v = win_start;
        v = (v / s) * s;
        return v[15:0];
    endfunction

    function automatic void publish_frame(input logic [15:0] f, output bit chg, output bit req);
        chg = 1'b0;
        req = 1'b0;
        if (committed != f && !req_pending)
        begin
            chg = 1'b1;
            req = 1'b1;
            req_pending = 1'b1;
            req_frame = f;
        end
        if (shared_tl && (!rep_valid || rep_frame != f))
        begin
            rep_valid = 1'b1;
            rep_frame = f;
            chg = 1'b1;
        end
    endfunction

    function automatic seq_outcome_t sequence_step(input opcode_t op,
                                                   input logic signed [16:0] fr);
        seq_outcome_t r;
        longint       d;
        logic [15:0]  f;
        bit           chg;
        bit           req;
        r = '0;
        unique case (op)
            OP_TICK:
            begin
                if (ticks < 16'hFFFF)
                    ticks++;
                if (mode >= MODE_FORWARD && mode <= MODE_PP_BWD && (!shared_tl || leader)
                    && (period == 0 || ticks >= period))
                begin
                    d = (step_size == 0) ? 1 : step_size;
                    if (mode >= MODE_PP_FWD)
                    begin
                        if (committed >= win_stop)
                            going_fwd = 1'b0;
                        if (committed <= win_start)
                            going_fwd = 1'b1;
                    end
                    else
                        going_fwd = 1'b1;
                    if (!going_fwd)
                        d = -d;
                    if (mode == MODE_BACKWARD || mode == MODE_PP_BWD)
                        d = -d;
                    f = fold_frame(longint'(committed) + d);
                    publish_frame(f, chg, req);
                    r.changed = chg;
                    r.request_issued = req;
                    r.requested_frame = f;
                end
            end
            OP_SEEK:
            begin
                f = fold_frame(longint'(fr));
                publish_frame(f, chg, req);
                r.changed = chg;
                r.request_issued = req;
                r.requested_frame = f;
            end
            OP_ACK:
            begin
                r.unexpected_frame = req_pending && (longint'(fr) != longint'(req_frame));
                req_pending = 1'b0;
                f = fr[15:0];
                if (committed != f)
                begin
                    committed = f;
                    ticks = '0;
                end
            end
            default:
            begin
            end
        endcase
        r.current_frame = committed;
        return r;
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failed = 1'b1;
        end
    endtask

    always @(posedge clk)
    begin
        seq_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, actual frame %0d",
                         $time, current_frame);
                failed = 1'b1;
            end
            else
            begin
                want = outcome_q.pop_front();
                compare_field("changed", want.changed, changed);
                compare_field("request_issued", want.request_issued, request_issued);
                compare_field("requested_frame", want.requested_frame, requested_frame);
                compare_field("current_frame", want.current_frame, current_frame);
                compare_field("unexpected_frame", want.unexpected_frame, unexpected_frame);
            end
        end
    end

    task automatic send_item(input opcode_t op, input logic [16:0] fr);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 6) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        frame <= fr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        outcome_q.push_back(sequence_step(op, fr));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[15:0];
        @(posedge clk);
        unique case (idx)
            REG_NUM_FRAMES:   n_frames = val & 16'hFFFF;
            REG_START_FRAME:  win_start = val & 16'hFFFF;
            REG_STOP_FRAME:   win_stop = val & 16'hFFFF;
            REG_SKIP:         step_size = val & 8'hFF;
            REG_PLAY_MODE:    mode = val[2:0];
            REG_PERIOD_TICKS: period = val & 16'hFFFF;
            REG_SYNC_ENABLED: shared_tl = val[0];
            default:          leader = val[0];
        endcase
    endtask

    task automatic configure(input longint nf, input longint st, input longint sp,
                             input longint sk, input logic [2:0] pm, input longint per,
                             input bit sy, input bit ld);
        settle();
        write_reg(REG_NUM_FRAMES, nf);
        write_reg(REG_START_FRAME, st);
        write_reg(REG_STOP_FRAME, sp);
        write_reg(REG_SKIP, sk);
        write_reg(REG_PLAY_MODE, longint'(pm));
        write_reg(REG_PERIOD_TICKS, per);
        write_reg(REG_SYNC_ENABLED, longint'(sy));
        write_reg(REG_IS_LEADER, longint'(ld));
        cfg_write <= 1'b0;
    endtask

    task automatic test_defaults();
        send_item(OP_TICK, 17'd0);
        send_item(OP_TICK, 17'd0);
        send_item(OP_SEEK, 17'd5);
        send_item(OP_NONE, 17'h1FFFF);
    endtask

    task automatic test_seek_extremes();
        configure(65535, 0, 65535, 1, MODE_STOPPED, 1, 1'b0, 1'b1);
        send_item(OP_SEEK, 17'h0FFFF);
        send_item(OP_SEEK, 17'h10000);
        send_item(OP_ACK, 17'h1FFFF);
        send_item(OP_SEEK, 17'd7);
        send_item(OP_ACK, 17'd7);
    endtask

    task automatic test_window_and_skip();
        configure(1000, 700, 100, 3, MODE_STOPPED, 1, 1'b0, 1'b1);
        send_item(OP_SEEK, 17'd50);
        configure(1000, 100, 299, 255, MODE_STOPPED, 1, 1'b1, 1'b1);
        send_item(OP_SEEK, 17'd999);
        send_item(OP_SEEK, 17'd390);
    endtask

    task automatic test_ping_pong();
        configure(20, 5, 9, 2, MODE_PP_FWD, 0, 1'b0, 1'b1);
        send_item(OP_SEEK, 17'd5);
        send_item(OP_ACK, {1'b0, req_frame});
        repeat (3)
        begin
            send_item(OP_TICK, 17'd0);
            send_item(OP_ACK, {1'b0, req_frame});
        end
        configure(20, 5, 9, 2, MODE_PP_BWD, 0, 1'b0, 1'b1);
        send_item(OP_TICK, 17'd0);
        send_item(OP_ACK, {1'b0, req_frame});
    endtask

    task automatic test_follower_and_unused();
        configure(20, 0, 19, 0, MODE_FORWARD, 0, 1'b1, 1'b0);
        send_item(OP_TICK, 17'd0);
        configure(20, 0, 19, 0, MODE_UNUSED, 0, 1'b0, 1'b1);
        send_item(OP_TICK, 17'd0);
        configure(20, 0, 19, 0, MODE_FORWARD, 0, 1'b0, 1'b1);
        send_item(OP_TICK, 17'd0);
        send_item(OP_NONE, 17'd3);
    endtask

    // Stopped ticks run the counter up to the period, then one advancing tick follows.
    task automatic test_tick_period();
        configure(100, 0, 99, 1, MODE_STOPPED, 40, 1'b0, 1'b1);
        repeat (40) send_item(OP_TICK, 17'd0);
        configure(100, 0, 99, 1, MODE_FORWARD, 40, 1'b0, 1'b1);
        send_item(OP_TICK, 17'd0);
    endtask

    task automatic random_settings();
        longint     nf;
        longint     lim;
        longint     st;
        longint     sp;
        longint     sk;
        longint     per;
        logic [2:0] pm;
        case ($urandom_range(3))
            0:       nf = 0;
            1:       nf = longint'($urandom_range(1, 64));
            2:       nf = 65535;
            default: nf = longint'($urandom_range(65535));
        endcase
        lim = (nf == 0) ? 64 : nf;
        if ($urandom_range(4) == 0)
        begin
            st = longint'($urandom_range(65535));
            sp = longint'($urandom_range(65535));
        end
        else
        begin
            st = longint'($urandom_range(int'(lim / 2)));
            sp = st + longint'($urandom_range(int'(lim / 2)));
        end
        case ($urandom_range(5))
            0:       sk = 0;
            1:       sk = 255;
            2:       sk = longint'($urandom_range(1, 255));
            default: sk = longint'($urandom_range(1, 4));
        endcase
        pm = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
        case ($urandom_range(7))
            0:       per = 65535;
            1:       per = longint'($urandom_range(65535));
            default: per = longint'($urandom_range(3));
        endcase
        configure(nf, st, sp, sk, pm, per, 1'($urandom_range(1)), $urandom_range(4) != 0);
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int count);
        int roll;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                random_settings();
            roll = $urandom_range(99);
            if (req_pending && roll < 55)
            begin
                if ($urandom_range(9) == 0)
                    send_item(OP_ACK, 17'($urandom()));
                else
                    send_item(OP_ACK, {1'b0, req_frame});
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 60)
                    send_item(OP_TICK, 17'($urandom()));
                else if (roll < 70)
                    send_item(OP_SEEK, 17'($urandom()));
                else if (roll < 80)
                    send_item(OP_SEEK, 17'($urandom_range(300)));
                else if (roll < 95)
                    send_item(OP_ACK, 17'($urandom()));
                else
                    send_item(OP_NONE, 17'($urandom()));
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_NUM_FRAMES;
        cfg_data <= '0;
        in_valid <= 1'b0;
        opcode <= OP_TICK;
        frame <= '0;
        out_stall <= 1'b0;
        failed = 1'b0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_frames = 0;
        win_start = 0;
        win_stop = 0;
        step_size = 1;
        mode = MODE_FORWARD;
        period = 1;
        shared_tl = 1'b1;
        leader = 1'b1;
        committed = '0;
        req_pending = 1'b0;
        req_frame = '0;
        rep_valid = 1'b0;
        rep_frame = '0;
        going_fwd = 1'b1;
        ticks = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_seek_extremes();
        test_window_and_skip();
        test_ping_pong();
        test_follower_and_unused();
        test_tick_period();
        test_random(0, 0, 435);
        test_random(59, 0, 435);
        test_random(0, 59, 435);
        test_random(21, 21, 435);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
